[design/maf_pkg.sv]
package maf_pkg;

  localparam int SAMPLE_W          = 32;
  localparam int AVG_W             = 40;
  localparam int HELD_W            = 9;
  localparam int WS_W              = 9;
  localparam int MAX_WINDOW_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [WS_W-1:0] WS_RESET = WS_W'(16);

endpackage

[design/maf_ram.sv]
module maf_ram
  import maf_pkg::*;
#(
  parameter int DEPTH = MAX_WINDOW_DEF,
  parameter int AW    = $clog2(MAX_WINDOW_DEF)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/maf_div.sv]
module maf_div #(
  parameter int DW = 48,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [VW+1:0] diff;

  // restoring step: one quotient bit per cycle, dividend bits shift out of q_r
  always_comb begin
    diff    = {1'b0, rem_r, q_r[DW-1]} - {2'b00, div_r};
    rem_nxt = diff[VW+1] ? {rem_r[VW-2:0], q_r[DW-1]} : diff[VW-1:0];
    q_nxt   = {q_r[DW-2:0], ~diff[VW+1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[design/moving_average_filter.sv]
// Each input passes the subtract, add, divider start, divider wait and finish states
//   before its result is registered.
// One transaction at a time; a new input waits until the last result is registered.
//   The restoring divider, producing one quotient bit per cycle, sets the pace.
// Reset (rst_n, synchronous, active low): window size 16, sum, position and count zero.
// Sample store contents are undefined after reset; no clearing pass is run.
module moving_average_filter
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [WS_W-1:0]            cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [AVG_W-1:0]    out_average,
  output logic [HELD_W-1:0]          out_samples_held
);

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + PW;
  localparam int QW    = SUM_W + FRACTION_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_ADD,
    S_DSTART,
    S_DWAIT,
    S_FIN
  } state_t;

  state_t                     state_r;
  logic [WS_W-1:0]            ws_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [PW-1:0]              pos_r;
  logic [CNT_W-1:0]           fill_r;
  logic                       full_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       out_valid_r;
  logic signed [AVG_W-1:0]    avg_r;
  logic [HELD_W-1:0]          held_r;

  logic [CNT_W-1:0]           n_eff;
  logic [PW-1:0]              pos_cur;
  logic [CNT_W-1:0]           pos_inc;
  logic [PW-1:0]              pos_nxt;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]           sum_mag;
  logic [QW-1:0]              dividend;
  logic                       div_start;
  logic                       div_done;
  logic [QW-1:0]              div_quot;
  logic [QW-1:0]              avg_res;
  logic                       in_acc;

  // zero acts as a window of one, oversize saturates to the store depth
  always_comb begin
    if (ws_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(ws_r) > 32'(MAX_WINDOW)) begin
      n_eff = CNT_W'(MAX_WINDOW);
    end else begin
      n_eff = CNT_W'(ws_r);
    end
  end

  assign pos_cur   = (CNT_W'(pos_r) >= n_eff) ? '0 : pos_r;
  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_nxt   = (pos_inc >= n_eff) ? '0 : PW'(pos_inc);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign div_start = (state_r == S_DSTART);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dividend  = QW'(sum_mag) << FRACTION_BITS;
  assign avg_res   = sum_r[SUM_W-1] ? QW'(-div_quot) : div_quot;

  maf_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == S_SUB),
    .waddr (pos_r),
    .wdata (sample_r),
    .raddr (pos_cur),
    .rdata (old_sample)
  );

  maf_div #(
    .DW (QW),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= WS_RESET;
      sum_r       <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        ws_r   <= cfg_wdata;
        sum_r  <= '0;
        pos_r  <= '0;
        fill_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sample_r <= in_sample;
            pos_r    <= pos_cur;
            full_r   <= (fill_r >= n_eff);
            state_r  <= S_SUB;
          end
        end
        S_SUB: begin
          // oldest sample leaves the sum once the window is full
          if (full_r) begin
            sum_r  <= sum_r - SUM_W'(old_sample);
            fill_r <= n_eff;
          end else begin
            fill_r <= fill_r + CNT_W'(1);
          end
          pos_r   <= pos_nxt;
          state_r <= S_ADD;
        end
        S_ADD: begin
          sum_r   <= sum_r + SUM_W'(sample_r);
          state_r <= S_DSTART;
        end
        S_DSTART: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            avg_r       <= AVG_W'($signed(avg_res));
            held_r      <= HELD_W'(fill_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average      = avg_r;
  assign out_samples_held = held_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DWAIT))
    else $error("divider finished outside its wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input still ready after accepting a transaction");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_eff)
    else $error("fill count beyond window length");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finishing step");

  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DWAIT) && !div_start)
    else $error("divider start not followed by wait");

endmodule
